[rtl/vdi_pkg.sv]
package vdi_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // field widths
  localparam int SP_W     = 16;  // setpoint
  localparam int VOLT_W   = 15;  // table voltage
  localparam int DUTY_W   = 10;
  localparam int EIDX_W   = 4;   // entry_index field
  localparam int STAT_W   = 2;
  localparam int PROD_W   = DUTY_W + VOLT_W;
  localparam int STEP_W   = $clog2(DUTY_W);

  // stream words
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIM = 2'd2;

  // commands and status codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_APPLY = 1'b1;
  localparam logic [STAT_W-1:0] STAT_INTERP = 2'd0;
  localparam logic [STAT_W-1:0] STAT_WINDOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_SEG = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP_LO,
    ST_CLAMP_HI,
    ST_SCAN_FIRST,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } vdi_state_t;

  // request to the multiply/divide unit
  typedef struct packed {
    logic              start;
    logic [DUTY_W-1:0] mag;  // |d1 - d0|
    logic [VOLT_W-1:0] dx;   // v - v0
    logic [VOLT_W-1:0] dn;   // v1 - v0, never zero
  } vdi_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DUTY_W-1:0] quot;
  } vdi_div_rsp_t;

endpackage

[rtl/voltage_to_duty_interpolator.sv]
// Voltage-to-duty interpolator. A load word (tuser = 0) writes one voltage/duty
// calibration pair into the table and gives no result. An apply word
// (tuser = 1) gives one result word: a setpoint outside
// [min_setpoint, max_setpoint] drives duty_limit with the output disabled;
// otherwise the setpoint is clamped to the first and last table voltages, the
// first bracketing segment is found and the duty is interpolated with a
// truncating signed division and saturated at duty_limit; if no segment
// brackets it, the duty is zero with status STAT_NO_SEG. The table is a
// single-read-port memory, so the clamp reads the first and then the last
// entry and the segment search reads the entries one after another; the
// interpolation then goes through one multiply/restoring-divide unit: first
// the multiply, then the 10 quotient bits one by one, most significant first.
// tready is low while an apply is in progress; one finished result may wait
// in the output register while the next word is taken.
// Table entries read before being written return undefined data.
module voltage_to_duty_interpolator
  import vdi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // slave side
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // entry_index[3:0], entry_voltage[18:4], entry_duty[28:19], set_voltage[44:29]
  input  logic [S_DATA_W-1:0]   s_tdata,
  // command (0 load, 1 apply)
  input  logic                  s_tuser,
  // master side
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // duty[9:0], output_enable[10]
  output logic [M_DATA_W-1:0]   m_tdata,
  // status
  output logic [STAT_W-1:0]     m_tuser,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // word fields
  logic [EIDX_W-1:0] in_idx;
  logic [VOLT_W-1:0] in_volt;
  logic [DUTY_W-1:0] in_duty;
  logic [SP_W-1:0]   in_sp;

  assign in_idx  = s_tdata[3:0];
  assign in_volt = s_tdata[18:4];
  assign in_duty = s_tdata[28:19];
  assign in_sp   = s_tdata[44:29];

  // configuration registers
  logic [SP_W-1:0]   min_sp;
  logic [SP_W-1:0]   max_sp;
  logic [DUTY_W-1:0] duty_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_sp   <= '0;
      max_sp   <= '1;
      duty_lim <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_SP:   min_sp   <= cfg_data;
        CFG_MAX_SP:   max_sp   <= cfg_data;
        CFG_DUTY_LIM: duty_lim <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic in_acc;
  logic apply_acc;
  logic load_acc;
  logic out_free;

  assign in_acc    = s_tvalid && s_tready;
  assign apply_acc = in_acc && (s_tuser == CMD_APPLY);
  assign load_acc  = in_acc && (s_tuser == CMD_LOAD);
  assign out_free  = !m_tvalid || m_tready;

  // calibration table, one write and one registered read a cycle
  logic [VOLT_W-1:0] table_v [TABLE_ENTRIES];
  logic [DUTY_W-1:0] table_d [TABLE_ENTRIES];
  logic [IDX_W-1:0]  rd_addr;
  logic [VOLT_W-1:0] rd_v;
  logic [DUTY_W-1:0] rd_d;
  logic              wr_en;

  assign wr_en = load_acc && (32'(in_idx) < TABLE_ENTRIES);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_v[IDX_W'(in_idx)] <= in_volt;
      table_d[IDX_W'(in_idx)] <= in_duty;
    end
    rd_v <= table_v[rd_addr];
    rd_d <= table_d[rd_addr];
  end

  // sequencer
  vdi_state_t state, state_next;

  logic [SP_W-1:0]   v;
  logic              clamped;
  logic [IDX_W-1:0]  idx;
  logic [VOLT_W-1:0] prev_v;
  logic [DUTY_W-1:0] prev_d;
  logic [DUTY_W-1:0] d0;
  logic              neg;
  logic [DUTY_W-1:0] res_duty;
  logic              res_en;
  logic [STAT_W-1:0] res_stat;

  logic              out_window;
  logic              below_lo;
  logic              above_hi;
  logic              seg_hit;
  logic              seg_flat;
  logic [SP_W-1:0]   dx_full;
  logic [VOLT_W-1:0] dn;
  logic              d_neg;
  logic [DUTY_W-1:0] d_mag;
  logic [DUTY_W:0]   interp;
  logic [DUTY_W-1:0] flat_sat;

  vdi_div_req_t div_req;
  vdi_div_rsp_t div_rsp;

  assign out_window = (v < min_sp) || (v > max_sp);
  assign below_lo   = v < SP_W'(rd_v);
  assign above_hi   = v > SP_W'(rd_v);
  // segment prev -> rd brackets v
  assign seg_hit    = (SP_W'(prev_v) <= v) && (SP_W'(rd_v) >= v);
  assign dn         = rd_v - prev_v;
  assign seg_flat   = (dn == '0);
  assign dx_full    = v - SP_W'(prev_v);
  assign d_neg      = rd_d < prev_d;
  assign d_mag      = d_neg ? (prev_d - rd_d) : (rd_d - prev_d);
  assign flat_sat   = (prev_d > duty_lim) ? duty_lim : prev_d;
  assign interp     = neg ? ({1'b0, d0} - {1'b0, div_rsp.quot})
                          : ({1'b0, d0} + {1'b0, div_rsp.quot});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (apply_acc) begin
          state_next = ST_CLAMP_LO;
        end
      end
      ST_CLAMP_LO: begin
        state_next = out_window ? ST_DONE : ST_CLAMP_HI;
      end
      ST_CLAMP_HI:   state_next = ST_SCAN_FIRST;
      ST_SCAN_FIRST: state_next = ST_SCAN;
      ST_SCAN: begin
        if (seg_hit) begin
          state_next = seg_flat ? ST_DONE : ST_DIV;
        end else if (idx == LAST_IDX) begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: ready, table address, divider request
  always_comb begin
    s_tready      = 1'b0;
    rd_addr       = '0;
    div_req.start = 1'b0;
    div_req.mag   = d_mag;
    div_req.dx    = dx_full[VOLT_W-1:0];
    div_req.dn    = dn;
    unique case (state)
      ST_IDLE:       s_tready = 1'b1;
      ST_CLAMP_LO:   rd_addr  = LAST_IDX;
      ST_CLAMP_HI:   rd_addr  = '0;
      ST_SCAN_FIRST: rd_addr  = IDX_W'(1);
      ST_SCAN: begin
        rd_addr       = idx + 1'b1;
        div_req.start = seg_hit && !seg_flat;
      end
      default: ;
    endcase
  end

  vdi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (apply_acc) begin
          v <= in_sp;
        end
      end
      ST_CLAMP_LO: begin
        // rd holds the first entry
        clamped  <= below_lo;
        if (below_lo) begin
          v <= SP_W'(rd_v);
        end
        res_duty <= duty_lim;
        res_en   <= 1'b0;
        res_stat <= STAT_WINDOW;
      end
      ST_CLAMP_HI: begin
        // rd holds the last entry
        if (!clamped && above_hi) begin
          v <= SP_W'(rd_v);
        end
      end
      ST_SCAN_FIRST: begin
        prev_v <= rd_v;
        prev_d <= rd_d;
        idx    <= IDX_W'(1);
      end
      ST_SCAN: begin
        res_en <= 1'b1;
        if (seg_hit) begin
          d0       <= prev_d;
          neg      <= d_neg;
          res_duty <= flat_sat;
          res_stat <= STAT_INTERP;
        end else begin
          prev_v   <= rd_v;
          prev_d   <= rd_d;
          idx      <= idx + 1'b1;
          res_duty <= '0;
          res_stat <= STAT_NO_SEG;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_duty <= (interp > {1'b0, duty_lim}) ? duty_lim : interp[DUTY_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= M_DATA_W'({res_en, res_duty});
      m_tuser <= res_stat;
    end
  end

endmodule

[rtl/vdi_div.sv]
module vdi_div
  import vdi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  vdi_div_req_t req,
  output vdi_div_rsp_t rsp
);

  logic              busy;
  logic              mul_pend;
  logic [STEP_W-1:0] step;
  logic [DUTY_W-1:0] mag;
  logic [VOLT_W-1:0] dx;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] dsh;
  logic [DUTY_W-1:0] quot;
  logic              done;
  logic              ge;

  // dx <= dn, so the quotient fits DUTY_W bits: DUTY_W restoring steps
  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      mul_pend <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        mul_pend <= 1'b1;
      end else if (mul_pend) begin
        mul_pend <= 1'b0;
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mag <= req.mag;
      dx  <= req.dx;
      dsh <= PROD_W'(req.dn) << (DUTY_W - 1);
    end else if (mul_pend) begin
      rem  <= PROD_W'(mag) * PROD_W'(dx);
      step <= STEP_W'(DUTY_W - 1);
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quot <= {quot[DUTY_W-2:0], ge};
      dsh  <= dsh >> 1;
      step <= step - 1'b1;
    end
  end

  assign rsp = {done, quot};

endmodule

[rtl/vdi_checker.sv]
module vdi_port_checker
  import vdi_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [S_DATA_W-1:0]   s_tdata,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [M_DATA_W-1:0]   m_tdata,
  input logic [STAT_W-1:0]     m_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // an apply occupies the block for at least the next cycle
  a_apply_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_APPLY) |=> !s_tready)
    else $error("ready after apply word");

  // after a load the block is ready again in the next cycle
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_LOAD) |=> s_tready)
    else $error("not ready after load word");

  // enable is low exactly for out-of-window results
  a_enable_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[DUTY_W] == (m_tuser != STAT_WINDOW)))
    else $error("output_enable disagrees with status");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word valid after reset");

endmodule

bind voltage_to_duty_interpolator vdi_port_checker u_vdi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[verif/vdi_checker.sv]
`timescale 1ns / 100ps

// Watches both stream channels and the register port, keeps its own copy of
// the calibration table and the window settings, and compares every result
// word with the oldest outstanding prediction.
module vdi_checker
  import vdi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_DATA_W-1:0]   m_tdata,
  input  logic [STAT_W-1:0]     m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int VOLT_LSB = EIDX_W;
  localparam int DUTY_LSB = VOLT_LSB + VOLT_W;
  localparam int SP_LSB   = DUTY_LSB + DUTY_W;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              enable;
    logic [STAT_W-1:0] status;
  } drive_t;

  logic [SP_W-1:0]   win_lo;
  logic [SP_W-1:0]   win_hi;
  logic [DUTY_W-1:0] duty_cap;
  logic [VOLT_W-1:0] cal_volt [TABLE_ENTRIES];
  logic [DUTY_W-1:0] cal_duty [TABLE_ENTRIES];
  drive_t            drive_q [$];

  function automatic drive_t interpolate_setpoint(input logic [SP_W-1:0] sp);
    drive_t r;
    int     v;
    int     lo;
    int     hi;
    int     d0;
    int     dd;
    int     q;
    bit     hit;
    r.duty   = '0;
    r.enable = 1'b1;
    r.status = STAT_NO_SEG;
    hit      = 1'b0;
    q        = 0;
    if (sp < win_lo || sp > win_hi) begin
      r.duty   = duty_cap;
      r.enable = 1'b0;
      r.status = STAT_WINDOW;
      return r;
    end
    // clamp tests the first voltage, then the last
    v = int'(sp);
    if (v < int'(cal_volt[0]))
      v = int'(cal_volt[0]);
    else if (v > int'(cal_volt[LAST_IDX]))
      v = int'(cal_volt[LAST_IDX]);
    // first bracketing segment wins
    for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
      lo = int'(cal_volt[i]);
      hi = int'(cal_volt[i+1]);
      if (!hit && lo <= v && hi >= v) begin
        hit = 1'b1;
        d0  = int'(cal_duty[i]);
        dd  = int'(cal_duty[i+1]) - d0;
        if (hi == lo)
          q = d0;
        else
          q = d0 + (dd * (v - lo)) / (hi - lo);
      end
    end
    if (hit) begin
      r.status = STAT_INTERP;
      r.duty   = (q > int'(duty_cap)) ? duty_cap : DUTY_W'(q);
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    drive_t want;
    drive_t got;
    if (rst) begin
      win_lo     = '0;
      win_hi     = '1;
      duty_cap   = '1;
      fail_count = 0;
      drive_q.delete();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        cal_volt[i] = '0;
        cal_duty[i] = '0;
      end
    end else begin
      if (m_tvalid && m_tready) begin
        got.duty   = m_tdata[DUTY_W-1:0];
        got.enable = m_tdata[DUTY_W];
        got.status = m_tuser;
        if (drive_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual duty %0d enable %0d status %0d",
                   $time, got.duty, got.enable, got.status);
          fail_count++;
        end else begin
          want = drive_q.pop_front();
          if (got.duty !== want.duty)
            $display("%0t: duty mismatch, expected %0d, actual %0d",
                     $time, want.duty, got.duty);
          if (got.enable !== want.enable)
            $display("%0t: output_enable mismatch, expected %0d, actual %0d",
                     $time, want.enable, got.enable);
          if (got.status !== want.status)
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
          if (got !== want)
            fail_count++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_SP:   win_lo = cfg_data[SP_W-1:0];
          CFG_MAX_SP:   win_hi = cfg_data[SP_W-1:0];
          CFG_DUTY_LIM: duty_cap = cfg_data[DUTY_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_LOAD) begin
          cal_volt[s_tdata[EIDX_W-1:0]] = s_tdata[VOLT_LSB +: VOLT_W];
          cal_duty[s_tdata[EIDX_W-1:0]] = s_tdata[DUTY_LSB +: DUTY_W];
        end else begin
          drive_q.push_back(interpolate_setpoint(s_tdata[SP_LSB +: SP_W]));
        end
      end
    end
    pending = drive_q.size();
  end

endmodule

[verif/voltage_to_duty_interpolator_tb.sv]
`timescale 1ns / 100ps

module voltage_to_duty_interpolator_tb;
  import vdi_pkg::*;

  // register index with no register behind it; writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // cycles to let pass once nothing is expected
  localparam int SETTLE = 40;

  // receiver stall patterns
  typedef enum int {
    RX_OPEN,    // always ready
    RX_COIN,    // ready on a coin toss
    RX_SPARSE,  // ready in single, evenly spaced cycles
    RX_LONG     // long stalls, short ready windows
  } rx_mode_e;

  // calibration table shapes
  typedef enum int {
    TBL_RAMP,       // ascending, spread over the range
    TBL_STEPS,      // ascending with repeated voltages
    TBL_SCRAMBLED,  // no order at all
    TBL_PEAK_FIRST  // first voltage above all others: setpoints below it find no segment
  } shape_e;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic [STAT_W-1:0]     m_tuser;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count;
  int pending;

  // stimulus-side bookkeeping: word counts, bursts and what aims the setpoints
  int       words_sent = 0;
  int       burst_left = 0;
  int       cur_min    = 0;
  int       cur_max    = 65535;
  int       shadow_volt [TABLE_ENTRIES];

  rx_mode_e rx_mode    = RX_OPEN;
  int       rx_epoch   = 0;
  int       rx_phase   = 0;

  always #5 clk = ~clk;

  voltage_to_duty_interpolator uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vdi_checker chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result side: the stall pattern changes with each random-length epoch, so that
  // back-pressure lands on every phase of a conversion, with open stretches too.
  always @(negedge clk) begin
    if (rx_epoch == 0) begin
      rx_mode  = rx_mode_e'($urandom_range(0, 3));
      rx_epoch = $urandom_range(64, 512);
    end
    rx_epoch--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= (rx_phase % 4 == 0);
      default:   m_tready <= (rx_phase % 48 < 8);
    endcase
  end

  // One word on the input stream. The sender runs in bursts; between bursts it
  // may drop tvalid for a random gap (or carry straight on). tvalid stays high
  // across back-to-back words so it is never lowered and raised in one step.
  task automatic send_word(input logic cmd, input logic [EIDX_W-1:0] idx,
                           input logic [VOLT_W-1:0] volt,
                           input logic [DUTY_W-1:0] dty,
                           input logic [SP_W-1:0] sp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    // pad, set_voltage, entry_duty, entry_voltage, entry_index
    s_tdata  <= {3'b000, sp, dty, volt, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    words_sent++;
  endtask

  // Apply word: only set_voltage matters, the rest is filled with noise.
  task automatic apply(input logic [SP_W-1:0] sp);
    send_word(CMD_APPLY, 4'($urandom), 15'($urandom), 10'($urandom), sp);
  endtask

  task automatic load_entry(input int idx, input int volt, input int dty);
    shadow_volt[idx] = volt;
    send_word(CMD_LOAD, 4'(idx), 15'(volt), 10'(dty), 16'($urandom));
  endtask

  // Hold the sender until every result is back, then give any conversion
  // still running time to finish. Registers may be written after this.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // All three registers, with junk in the unused upper bits of the duty limit
  // and now and then a write to the spare index.
  task automatic program_regs(input int lo, input int hi, input int lim);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_SP;
    cfg_data  <= 16'(lo);
    @(negedge clk);
    cfg_index <= CFG_MAX_SP;
    cfg_data  <= 16'(hi);
    @(negedge clk);
    cfg_index <= CFG_DUTY_LIM;
    cfg_data  <= {6'($urandom), 10'(lim)};
    @(negedge clk);
    if ($urandom_range(0, 2) == 0) begin
      cfg_index <= CFG_SPARE;
      cfg_data  <= 16'($urandom);
      @(negedge clk);
    end
    cfg_we  <= 1'b0;
    cur_min = lo;
    cur_max = hi;
  endtask

  // A whole new table, loaded from a random starting index.
  task automatic load_table();
    shape_e shape;
    int     r;
    int     v;
    int     step_max;
    int     first;
    int     idx;
    int     dty;
    int     vols [TABLE_ENTRIES];
    r = $urandom_range(0, 19);
    shape = (r < 10) ? TBL_RAMP : (r < 15) ? TBL_STEPS :
            (r < 18) ? TBL_SCRAMBLED : TBL_PEAK_FIRST;
    case (shape)
      TBL_RAMP: begin
        v = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4000);
        step_max = (32767 - v) / 15;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          vols[i] = v;
          v += $urandom_range(0, step_max);
        end
        if ($urandom_range(0, 3) == 0)
          vols[TABLE_ENTRIES-1] = 32767;
      end
      TBL_STEPS: begin
        v = $urandom_range(0, 20000);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          vols[i] = v;
          if ($urandom_range(0, 2) == 0)
            v += $urandom_range(1, 800);
        end
      end
      TBL_SCRAMBLED: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          vols[i] = $urandom_range(0, 32767);
      end
      default: begin
        vols[0] = $urandom_range(30000, 32767);
        for (int i = 1; i < TABLE_ENTRIES; i++)
          vols[i] = $urandom_range(0, vols[0] - 1);
      end
    endcase
    first = $urandom_range(0, TABLE_ENTRIES - 1);
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      idx = (first + k) % TABLE_ENTRIES;
      case ($urandom_range(0, 15))
        0:       dty = 0;
        1:       dty = 1023;
        default: dty = $urandom_range(0, 1023);
      endcase
      load_entry(idx, vols[idx], dty);
    end
  endtask

  // Mostly inside the table span, with table points, window edges and the
  // extremes of the field mixed in.
  function automatic logic [SP_W-1:0] pick_setpoint();
    int lo;
    int hi;
    lo = shadow_volt[0];
    hi = shadow_volt[TABLE_ENTRIES-1];
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 16'($urandom_range(lo, hi));
      6: return 16'(shadow_volt[$urandom_range(0, TABLE_ENTRIES - 1)] +
                    $urandom_range(0, 2) - 1);
      7: begin
        case ($urandom_range(0, 3))
          0:       return 16'(cur_min - 1);
          1:       return 16'(cur_min);
          2:       return 16'(cur_max);
          default: return 16'(cur_max + 1);
        endcase
      end
      8: return 16'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'd0;
          1:       return 16'd65535;
          2:       return 16'd32767;
          default: return 16'd32768;
        endcase
      end
    endcase
  endfunction

  initial begin
    int start;
    int lo;
    int hi;
    int lim;
    int n;
    int guard;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // ---- directed ----
    // Ascending table: entries 0 and 1 share a voltage (zero-width segment),
    // segment 4 falls in duty, last entry sits at full scale.
    for (int i = 0; i < TABLE_ENTRIES; i++)
      load_entry(i,
                 (i < 2) ? 100 : (i == TABLE_ENTRIES - 1) ? 32767 : i * 2000,
                 (i == 0) ? 700 : (i == 1) ? 0 : (i == 5) ? 100 :
                 (i == TABLE_ENTRIES - 1) ? 1023 : i * 68);
    apply(16'd0);      // below the table: clamps onto the zero-width segment
    apply(16'd65535);  // above the table: clamps to the last voltage
    apply(16'd8000);   // exactly on a table point
    apply(16'd9001);   // falling segment, negative quotient truncates up

    // narrow window with a low duty limit: both edges and a saturated duty
    drain();
    program_regs(10000, 20000, 500);
    apply(16'd9999);
    apply(16'd20001);
    apply(16'd15000);

    // inverted window: everything out of window
    drain();
    program_regs(30000, 1000, 1023);
    apply(16'd5000);

    // first voltage raised to the last one's full scale: the last segment brackets the clamp
    drain();
    program_regs(0, 65535, 1023);
    load_entry(0, 32767, 1023);
    apply(16'd5000);

    // ---- random sessions ----
    // Each session: idle, new settings, new table, then a run of setpoints
    // with the odd stray reload that breaks the table's order.
    start = words_sent;
    while (words_sent - start < 1050) begin
      drain();
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          lo = 0;
          hi = 65535;
        end
        3: begin
          lo = $urandom_range(0, 32767);
          hi = $urandom_range(lo, 65535);
        end
        4: begin
          case ($urandom_range(0, 2))
            0:       lo = 0;
            1:       lo = 65535;
            default: lo = $urandom_range(0, 65535);
          endcase
          hi = lo;
        end
        default: begin
          lo = $urandom_range(1, 65535);
          hi = $urandom_range(0, lo - 1);
        end
      endcase
      case ($urandom_range(0, 5))
        0, 1, 2: lim = 1023;
        3:       lim = 0;
        default: lim = $urandom_range(0, 1023);
      endcase
      program_regs(lo, hi, lim);
      load_table();
      n = $urandom_range(30, 70);
      repeat (n) begin
        if ($urandom_range(0, 11) == 0)
          load_entry($urandom_range(0, TABLE_ENTRIES - 1), $urandom_range(0, 32767),
                     $urandom_range(0, 1023));
        else
          apply(pick_setpoint());
        if ($urandom_range(0, 149) == 0)
          drain();
      end
    end

    // ---- wind down ----
    s_tvalid <= 1'b0;
    for (guard = 0; guard < 50000 && pending != 0; guard++)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (pending != 0)
      $display("%0t: %0d result words never arrived", $time, pending);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // hard stop, several times the slowest legal run
  initial begin
    #6000000;
    $display("%0t: run timed out", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
